FILE: rtl/core/siq_pkg.sv
// ----------------------------------------------------------------------------
// siq_pkg
// Shared types, codes and default sizes for the sorted insert queue core.
// ----------------------------------------------------------------------------
package siq_pkg;

	// default sizes handed to the top level
	localparam int DEPTH_DEF      = 16;
	localparam int KEY_BITS_DEF   = 16;
	localparam int DATA_BITS_DEF  = 16;

	// fixed field widths
	localparam int REQ_BITS       = 3;
	localparam int STATUS_BITS    = 2;
	localparam int COUNT_OUT_BITS = 5;

	// request codes
	localparam logic [REQ_BITS-1:0] REQ_APPEND = 3'd0;
	localparam logic [REQ_BITS-1:0] REQ_INSERT = 3'd1;
	localparam logic [REQ_BITS-1:0] REQ_DEQUEUE = 3'd2;
	localparam logic [REQ_BITS-1:0] REQ_PEEK   = 3'd3;
	localparam logic [REQ_BITS-1:0] REQ_SEARCH = 3'd4;

	// result status codes
	localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATUS_BITS-1:0] STAT_MISS  = 2'd3;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_HEAD,
		S_WALK,
		S_TAIL,
		S_RESP
	} siq_state_t;

	// datapath operations
	typedef enum logic [2:0] {
		DP_IDLE,
		DP_SET_STATUS,
		DP_APPEND,
		DP_HEAD_RD,
		DP_HEAD_TAKE,
		DP_WALK_START,
		DP_WALK_STEP,
		DP_TAIL
	} siq_op_t;

	// controller to datapath
	typedef struct packed {
		logic                   latch_req;
		siq_op_t                op;
		logic [STATUS_BITS-1:0] set_status;
		logic                   load_out;
	} siq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [REQ_BITS-1:0] req_type;
		logic                full;
		logic                empty;
		logic                walk_last;
		logic                match;
		logic                out_free;
	} siq_stat_t;

endpackage

FILE: rtl/core/sorted_insert_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_insert_queue_core
// Bounded key/data queue with append, sorted insert, dequeue, peek and search.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | tuser: req_type; tdata: elem_key, elem_data
//  m_*     | out | m_tvalid/m_tready | tuser: status; tdata: out_key, out_data,
//          |     |                   |   entry_count
//  cfg_*   | in  | cfg_we            | cfg_wdata: signed_key_compare
//
//  One request at a time. Append, rejected or empty requests go from decode
//  straight to the result state; peek and dequeue pass through the head state.
//  Sorted insert walks every held entry and then writes the tail; search walks until a match or the last held entry.
//  The walk reads one entry per cycle through the single memory read port.
//  Reset clears the queue to empty and selects unsigned key order.
//  A result beat waits in the output register; a new request is accepted
//  meanwhile, and its own result waits until that register is free.
// ----------------------------------------------------------------------------
module sorted_insert_queue_core #(
	parameter int DEPTH     = siq_pkg::DEPTH_DEF,
	parameter int KEY_BITS  = siq_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS = siq_pkg::DATA_BITS_DEF,
	localparam int S_DW = ((KEY_BITS + DATA_BITS + 7) / 8) * 8,
	localparam int M_DW = ((KEY_BITS + DATA_BITS + siq_pkg::COUNT_OUT_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [S_DW-1:0]                 s_tdata,  // elem_key, elem_data, zero pad
	input  logic [siq_pkg::REQ_BITS-1:0]    s_tuser,  // req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [M_DW-1:0]                 m_tdata,  // out_key, out_data, entry_count, pad
	output logic [siq_pkg::STATUS_BITS-1:0] m_tuser   // status
);

	siq_pkg::siq_cmd_t  cmd;
	siq_pkg::siq_stat_t st;

	logic [KEY_BITS-1:0]                elem_key;
	logic [DATA_BITS-1:0]               elem_data;
	logic [KEY_BITS-1:0]                out_key;
	logic [DATA_BITS-1:0]               out_data;
	logic [siq_pkg::COUNT_OUT_BITS-1:0] entry_count;

	// unpack request beat
	assign elem_key  = s_tdata[KEY_BITS-1:0];
	assign elem_data = s_tdata[KEY_BITS+DATA_BITS-1:KEY_BITS];

	siq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	siq_dpath #(
		.DEPTH     (DEPTH),
		.KEY_BITS  (KEY_BITS),
		.DATA_BITS (DATA_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_req_type (s_tuser),
		.in_key      (elem_key),
		.in_data     (elem_data),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (m_tuser),
		.out_key     (out_key),
		.out_data    (out_data),
		.out_count   (entry_count)
	);

	// pack result beat
	assign m_tdata = M_DW'({entry_count, out_data, out_key});

endmodule

FILE: rtl/core/siq_ctrl.sv
// ----------------------------------------------------------------------------
// siq_ctrl
// Request sequencer: accepts a beat, decodes it and steps the datapath.
// ----------------------------------------------------------------------------
module siq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  siq_pkg::siq_stat_t st,
	output siq_pkg::siq_cmd_t  cmd
);

	siq_pkg::siq_state_t state_q;
	siq_pkg::siq_state_t state_nxt;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= siq_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			siq_pkg::S_IDLE: begin
				if (in_valid) state_nxt = siq_pkg::S_DECODE;
			end
			siq_pkg::S_DECODE: begin
				case (st.req_type) inside
					siq_pkg::REQ_APPEND: begin
						state_nxt = siq_pkg::S_RESP;
					end
					siq_pkg::REQ_INSERT: begin
						if (st.full || st.empty) state_nxt = siq_pkg::S_RESP;
						else                     state_nxt = siq_pkg::S_WALK;
					end
					siq_pkg::REQ_DEQUEUE, siq_pkg::REQ_PEEK: begin
						if (st.empty) state_nxt = siq_pkg::S_RESP;
						else          state_nxt = siq_pkg::S_HEAD;
					end
					siq_pkg::REQ_SEARCH: begin
						if (st.empty) state_nxt = siq_pkg::S_RESP;
						else          state_nxt = siq_pkg::S_WALK;
					end
					default: begin
						state_nxt = siq_pkg::S_RESP;
					end
				endcase
			end
			siq_pkg::S_HEAD: begin
				state_nxt = siq_pkg::S_RESP;
			end
			siq_pkg::S_WALK: begin
				if (st.req_type == siq_pkg::REQ_SEARCH) begin
					if (st.match || st.walk_last) state_nxt = siq_pkg::S_RESP;
				end else if (st.walk_last) begin
					state_nxt = siq_pkg::S_TAIL;
				end
			end
			siq_pkg::S_TAIL: begin
				state_nxt = siq_pkg::S_RESP;
			end
			siq_pkg::S_RESP: begin
				if (st.out_free) state_nxt = siq_pkg::S_IDLE;
			end
			default: begin
				state_nxt = siq_pkg::S_IDLE;
			end
		endcase
	end

	// drive datapath commands
	always_comb begin
		cmd            = '0;
		cmd.op         = siq_pkg::DP_IDLE;
		cmd.set_status = siq_pkg::STAT_OK;
		in_ready       = 1'b0;
		unique case (state_q)
			siq_pkg::S_IDLE: begin
				in_ready      = 1'b1;
				cmd.latch_req = in_valid;
			end
			siq_pkg::S_DECODE: begin
				case (st.req_type) inside
					siq_pkg::REQ_APPEND, siq_pkg::REQ_INSERT: begin
						if (st.full) begin
							cmd.op         = siq_pkg::DP_SET_STATUS;
							cmd.set_status = siq_pkg::STAT_FULL;
						end else if (st.req_type == siq_pkg::REQ_APPEND || st.empty) begin
							cmd.op = siq_pkg::DP_APPEND;
						end else begin
							cmd.op = siq_pkg::DP_WALK_START;
						end
					end
					siq_pkg::REQ_DEQUEUE, siq_pkg::REQ_PEEK: begin
						if (st.empty) begin
							cmd.op         = siq_pkg::DP_SET_STATUS;
							cmd.set_status = siq_pkg::STAT_EMPTY;
						end else begin
							cmd.op = siq_pkg::DP_HEAD_RD;
						end
					end
					siq_pkg::REQ_SEARCH: begin
						if (st.empty) begin
							cmd.op         = siq_pkg::DP_SET_STATUS;
							cmd.set_status = siq_pkg::STAT_MISS;
						end else begin
							cmd.op = siq_pkg::DP_WALK_START;
						end
					end
					default: begin
						cmd.op = siq_pkg::DP_IDLE;
					end
				endcase
			end
			siq_pkg::S_HEAD: begin
				cmd.op = siq_pkg::DP_HEAD_TAKE;
			end
			siq_pkg::S_WALK: begin
				cmd.op = siq_pkg::DP_WALK_STEP;
			end
			siq_pkg::S_TAIL: begin
				cmd.op = siq_pkg::DP_TAIL;
			end
			siq_pkg::S_RESP: begin
				cmd.load_out = st.out_free;
			end
			default: begin
				cmd.op = siq_pkg::DP_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/siq_dpath.sv
// ----------------------------------------------------------------------------
// siq_dpath
// Entry store as a ring over one memory, walk registers and result beat.
// ----------------------------------------------------------------------------
module siq_dpath #(
	parameter int DEPTH     = siq_pkg::DEPTH_DEF,
	parameter int KEY_BITS  = siq_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS = siq_pkg::DATA_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_wdata,
	input  logic [siq_pkg::REQ_BITS-1:0]     in_req_type,
	input  logic [KEY_BITS-1:0]              in_key,
	input  logic [DATA_BITS-1:0]             in_data,
	input  siq_pkg::siq_cmd_t                cmd,
	output siq_pkg::siq_stat_t               st,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [siq_pkg::STATUS_BITS-1:0]  out_status,
	output logic [KEY_BITS-1:0]              out_key,
	output logic [DATA_BITS-1:0]             out_data,
	output logic [siq_pkg::COUNT_OUT_BITS-1:0] out_count
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	// ring position of a queue offset
	function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] head, input logic [IW:0] off);
		logic [IW:0] sum;
		sum = {1'b0, head} + off;
		if (sum >= DEPTH_W) sum = sum - DEPTH_W;
		return sum[IW-1:0];
	endfunction

	// strict key order, unsigned or two's complement
	function automatic logic key_less(input logic [KEY_BITS-1:0] a, input logic [KEY_BITS-1:0] b,
		input logic sgn);
		logic [KEY_BITS-1:0] ax;
		logic [KEY_BITS-1:0] bx;
		ax = a;
		bx = b;
		if (sgn) begin
			ax[KEY_BITS-1] = ~a[KEY_BITS-1];
			bx[KEY_BITS-1] = ~b[KEY_BITS-1];
		end
		return ax < bx;
	endfunction

	logic                            signed_cmp_q;
	logic [siq_pkg::REQ_BITS-1:0]    req_type_q;
	logic [KEY_BITS-1:0]             req_key_q;
	logic [DATA_BITS-1:0]            req_data_q;
	logic [CW-1:0]                   count_q;
	logic [IW-1:0]                   head_q;
	logic [IW-1:0]                   idx_q;
	logic                            placing_q;
	logic [KEY_BITS-1:0]             carry_key_q;
	logic [DATA_BITS-1:0]            carry_data_q;
	logic [siq_pkg::STATUS_BITS-1:0] res_status_q;
	logic [KEY_BITS-1:0]             res_key_q;
	logic [DATA_BITS-1:0]            res_data_q;
	logic                            out_valid_q;
	logic [siq_pkg::STATUS_BITS-1:0] out_status_q;
	logic [KEY_BITS-1:0]             out_key_q;
	logic [DATA_BITS-1:0]            out_data_q;
	logic [siq_pkg::COUNT_OUT_BITS-1:0] out_count_q;

	logic [KEY_BITS-1:0]  key_mem  [DEPTH];
	logic [DATA_BITS-1:0] data_mem [DEPTH];
	logic [KEY_BITS-1:0]  rd_key_q;
	logic [DATA_BITS-1:0] rd_data_q;

	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	logic [KEY_BITS-1:0]  wr_key;
	logic [DATA_BITS-1:0] wr_data;
	logic [IW-1:0]        rd_addr;

	logic                 is_insert;
	logic                 rd_less;
	logic                 rd_match;
	logic                 walk_last;
	logic [IW:0]          count_off;
	logic [IW:0]          idx_off;

	assign is_insert = (req_type_q == siq_pkg::REQ_INSERT);
	assign rd_less   = key_less(rd_key_q, req_key_q, signed_cmp_q);
	assign rd_match  = (rd_key_q == req_key_q);
	assign count_off = (IW + 1)'(count_q);
	assign idx_off   = {1'b0, idx_q};
	assign walk_last = (idx_off == count_off - 1'b1);

	// status to controller
	assign st.req_type  = req_type_q;
	assign st.full      = (count_q == DEPTH_C);
	assign st.empty     = (count_q == '0);
	assign st.walk_last = walk_last;
	assign st.match     = rd_match;
	assign st.out_free  = !out_valid_q || out_ready;

	// select memory addresses and write data
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ring_pos(head_q, count_off);
		wr_key  = req_key_q;
		wr_data = req_data_q;
		rd_addr = head_q;
		case (cmd.op)
			siq_pkg::DP_APPEND: begin
				wr_en = 1'b1;
			end
			siq_pkg::DP_WALK_STEP: begin
				rd_addr = ring_pos(head_q, idx_off + 1'b1);
				wr_addr = ring_pos(head_q, idx_off);
				if (is_insert) begin
					if (placing_q) begin
						wr_en   = 1'b1;
						wr_key  = carry_key_q;
						wr_data = carry_data_q;
					end else if (!rd_less) begin
						wr_en = 1'b1;
					end
				end
			end
			siq_pkg::DP_TAIL: begin
				wr_en   = 1'b1;
				wr_key  = carry_key_q;
				wr_data = carry_data_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]  <= wr_key;
			data_mem[wr_addr] <= wr_data;
		end
		rd_key_q  <= key_mem[rd_addr];
		rd_data_q <= data_mem[rd_addr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_cmp_q <= 1'b0;
		end else if (cfg_we) begin
			signed_cmp_q <= cfg_wdata;
		end
	end

	// queue control: count, head, walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			head_q    <= '0;
			idx_q     <= '0;
			placing_q <= 1'b0;
		end else begin
			case (cmd.op)
				siq_pkg::DP_APPEND, siq_pkg::DP_TAIL: begin
					count_q <= count_q + 1'b1;
				end
				siq_pkg::DP_HEAD_TAKE: begin
					if (req_type_q == siq_pkg::REQ_DEQUEUE) begin
						count_q <= count_q - 1'b1;
						head_q  <= ring_pos(head_q, (IW + 1)'(1));
					end
				end
				siq_pkg::DP_WALK_START: begin
					idx_q     <= '0;
					placing_q <= 1'b0;
				end
				siq_pkg::DP_WALK_STEP: begin
					idx_q <= idx_q + 1'b1;
					if (is_insert && !rd_less) placing_q <= 1'b1;
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// request capture, carried entry and result
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_type_q   <= in_req_type;
			req_key_q    <= in_key;
			req_data_q   <= in_data;
			res_status_q <= siq_pkg::STAT_OK;
			res_key_q    <= '0;
			res_data_q   <= '0;
		end
		case (cmd.op)
			siq_pkg::DP_SET_STATUS: begin
				res_status_q <= cmd.set_status;
			end
			siq_pkg::DP_HEAD_TAKE: begin
				res_key_q  <= rd_key_q;
				res_data_q <= rd_data_q;
			end
			siq_pkg::DP_WALK_STEP: begin
				if (is_insert) begin
					if (placing_q || !rd_less) begin
						carry_key_q  <= rd_key_q;
						carry_data_q <= rd_data_q;
					end else if (walk_last) begin
						carry_key_q  <= req_key_q;
						carry_data_q <= req_data_q;
					end
				end else if (rd_match) begin
					res_key_q  <= rd_key_q;
					res_data_q <= rd_data_q;
				end else if (walk_last) begin
					res_status_q <= siq_pkg::STAT_MISS;
				end
			end
			default: begin
				// hold the result
			end
		endcase
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_key_q    <= res_key_q;
			out_data_q   <= res_data_q;
			out_count_q  <= siq_pkg::COUNT_OUT_BITS'(count_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_key    = out_key_q;
	assign out_data   = out_data_q;
	assign out_count  = out_count_q;

	// checks
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above depth");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, head_q} < DEPTH_W)
		else $error("head pointer out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result beat overwritten");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == siq_pkg::DP_WALK_STEP) |-> (idx_off < count_off))
		else $error("walk beyond held entries");

	a_grow_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == siq_pkg::DP_APPEND || cmd.op == siq_pkg::DP_TAIL) |-> (count_q != DEPTH_C))
		else $error("push into a full queue");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_insert_queue_core. A shadow queue predicts
// every response beat from the accepted requests. Directed corner requests
// come first, then random runs that lean towards filling, mixing or draining
// the queue under both key orders. Random back-pressure runs on both streams,
// and one long output stall forces the core to block its input.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KW     = siq_pkg::KEY_BITS_DEF;
	localparam int DW     = siq_pkg::DATA_BITS_DEF;
	localparam int QD     = siq_pkg::DEPTH_DEF;
	localparam int RB     = siq_pkg::REQ_BITS;
	localparam int SB     = siq_pkg::STATUS_BITS;
	localparam int CB     = siq_pkg::COUNT_OUT_BITS;
	localparam int S_BITS = ((KW + DW + 7) / 8) * 8;
	localparam int M_BITS = ((KW + DW + CB + 7) / 8) * 8;

	localparam int unsigned SETTLE_CYCLES    = 2 * QD + 8;
	localparam int unsigned LONG_HOLD_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT      = 600000;
	localparam int unsigned ITEMS_PER_LEG    = 242;
	localparam int unsigned MAX_PRINTED      = 100;

	typedef struct {
		logic [SB-1:0] status;
		logic [KW-1:0] key;
		logic [DW-1:0] data;
		logic [CB-1:0] count;
	} queue_reply_t;

	// shadow of the queue contents and the responses still owed
	class queue_scoreboard;
		logic [KW-1:0] keys [QD];
		logic [DW-1:0] vals [QD];
		int            held;
		bit            signed_order;
		queue_reply_t  awaited [$];
		int unsigned   errors;

		function new();
			held         = 0;
			signed_order = 1'b0;
			errors       = 0;
		endfunction

		function bit key_before(logic [KW-1:0] a, logic [KW-1:0] b);
			if (signed_order)
				return $signed(a) < $signed(b);
			return a < b;
		endfunction

		// apply one accepted request to the shadow and queue its response
		function void note_request(logic [RB-1:0] req, logic [KW-1:0] key,
				logic [DW-1:0] data);
			queue_reply_t r;
			int           pos;
			r.status = siq_pkg::STAT_OK;
			r.key    = '0;
			r.data   = '0;
			case (req)
				siq_pkg::REQ_APPEND, siq_pkg::REQ_INSERT: begin
					if (held >= QD) begin
						r.status = siq_pkg::STAT_FULL;
					end else begin
						pos = held;
						if (req == siq_pkg::REQ_INSERT) begin
							// stop at the first key that is not smaller
							pos = 0;
							while (pos < held && key_before(keys[pos], key))
								pos++;
							for (int i = held; i > pos; i--) begin
								keys[i] = keys[i-1];
								vals[i] = vals[i-1];
							end
						end
						keys[pos] = key;
						vals[pos] = data;
						held++;
					end
				end
				siq_pkg::REQ_DEQUEUE, siq_pkg::REQ_PEEK: begin
					if (held == 0) begin
						r.status = siq_pkg::STAT_EMPTY;
					end else begin
						r.key  = keys[0];
						r.data = vals[0];
						if (req == siq_pkg::REQ_DEQUEUE) begin
							for (int i = 1; i < held; i++) begin
								keys[i-1] = keys[i];
								vals[i-1] = vals[i];
							end
							held--;
						end
					end
				end
				siq_pkg::REQ_SEARCH: begin
					r.status = siq_pkg::STAT_MISS;
					for (int i = 0; i < held; i++) begin
						if (keys[i] == key) begin
							r.status = siq_pkg::STAT_OK;
							r.key    = keys[i];
							r.data   = vals[i];
							break;
						end
					end
				end
				default: begin
					// unused codes leave the queue alone
				end
			endcase
			r.count = CB'(held);
			awaited.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("mismatch at %0t ns: %s", $time, msg);
		endtask

		// compare one response beat with the oldest owed response
		task check_result(logic [SB-1:0] status, logic [KW-1:0] key,
				logic [DW-1:0] data, logic [CB-1:0] count);
			queue_reply_t e;
			if (awaited.size() == 0) begin
				report("response beat with no request outstanding");
				return;
			end
			e = awaited.pop_front();
			if (status !== e.status)
				report($sformatf("status %0d, expected %0d", status, e.status));
			if (key !== e.key)
				report($sformatf("out_key %h, expected %h", key, e.key));
			if (data !== e.data)
				report($sformatf("out_data %h, expected %h", data, e.data));
			if (count !== e.count)
				report($sformatf("entry_count %0d, expected %0d", count, e.count));
		endtask
	endclass

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic                      cfg_wdata = 1'b0;
	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [S_BITS-1:0]         s_tdata   = '0;  // elem_key, elem_data
	logic [RB-1:0]             s_tuser   = '0;  // req_type
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	logic [M_BITS-1:0]         m_tdata;         // out_key, out_data, entry_count
	logic [SB-1:0]             m_tuser;         // status

	queue_scoreboard sb;
	int unsigned     tx_idle_pct  = 0;
	int unsigned     rx_idle_pct  = 0;
	bit              long_hold    = 1'b0;
	bit              hold_served  = 1'b0;
	int unsigned     cycle_count  = 0;

	sorted_insert_queue_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// abandon a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// record accepted request beats
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_request(s_tuser, s_tdata[KW-1:0], s_tdata[KW+DW-1:KW]);
	end

	// check accepted response beats
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata[KW-1:0], m_tdata[KW+DW-1:KW],
				m_tdata[KW+DW+CB-1:KW+DW]);
	end

	// response side: random stalls, plus one long hold on request
	initial begin
		int unsigned held_for;
		forever begin
			@(posedge clk);
			if (long_hold && !hold_served) begin
				m_tready <= 1'b0;
				for (held_for = 0; held_for < LONG_HOLD_CYCLES; held_for++)
					@(posedge clk);
				hold_served = 1'b1;
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// offer one request beat and hold it until taken
	task automatic send_request(logic [RB-1:0] req, logic [KW-1:0] key,
			logic [DW-1:0] data);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= S_BITS'({data, key});
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// stop offering and wait for every owed response
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_order(bit signed_keys);
		cfg_we    <= 1'b1;
		cfg_wdata <= signed_keys;
		@(posedge clk);
		cfg_we          <= 1'b0;
		sb.signed_order = signed_keys;
	endtask

	// favour corner keys, small keys that repeat, and keys about minus one
	function automatic logic [KW-1:0] draw_key();
		logic [KW-1:0] corners [6];
		corners = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF};
		case ($urandom_range(3))
			0:       return corners[$urandom_range(5)];
			1:       return KW'($urandom_range(7));
			2:       return 16'hFFF8 | KW'($urandom_range(7));
			default: return KW'($urandom);
		endcase
	endfunction

	task automatic random_request(int unsigned push_pct);
		int unsigned   roll;
		logic [RB-1:0] req;
		logic [KW-1:0] key;
		logic [DW-1:0] data;
		key  = draw_key();
		data = DW'($urandom);
		roll = $urandom_range(99);
		if (roll < push_pct) begin
			req = ($urandom_range(99) < 60) ? siq_pkg::REQ_INSERT : siq_pkg::REQ_APPEND;
		end else begin
			roll = $urandom_range(99);
			if (roll < 40) begin
				req = siq_pkg::REQ_DEQUEUE;
			end else if (roll < 60) begin
				req = siq_pkg::REQ_PEEK;
			end else if (roll < 95) begin
				req = siq_pkg::REQ_SEARCH;
				// search for a held key half of the time
				if (sb.held != 0 && $urandom_range(1) == 1)
					key = sb.keys[$urandom_range(sb.held - 1)];
			end else begin
				req = RB'(siq_pkg::REQ_SEARCH + 1 + $urandom_range(2));
			end
		end
		send_request(req, key, data);
	endtask

	// runs that lean towards filling, mixing or draining the queue
	task automatic random_burst(int unsigned items);
		int unsigned left;
		int unsigned run_len;
		int unsigned push_pct;
		left = items;
		while (left != 0) begin
			run_len = $urandom_range(10, 50);
			if (run_len > left)
				run_len = left;
			case ($urandom_range(2))
				0:       push_pct = 85;
				1:       push_pct = 50;
				default: push_pct = 20;
			endcase
			repeat (run_len) random_request(push_pct);
			left -= run_len;
		end
	endtask

	initial begin
		bit order;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_order(1'b0);

		// empty queue, unused code, then a mixed-sign sorted fill with a tie
		send_request(siq_pkg::REQ_PEEK,    16'h0000, 16'h0000);
		send_request(siq_pkg::REQ_DEQUEUE, 16'hFFFF, 16'hFFFF);
		send_request(siq_pkg::REQ_SEARCH,  16'h0000, 16'h0000);
		send_request(RB'(siq_pkg::REQ_SEARCH + 1), 16'hFFFF, 16'hFFFF);
		send_request(siq_pkg::REQ_INSERT,  16'h8000, 16'h0001);
		send_request(siq_pkg::REQ_INSERT,  16'h0001, 16'hAAAA);
		send_request(siq_pkg::REQ_INSERT,  16'hFFFF, 16'hFFFF);
		send_request(siq_pkg::REQ_INSERT,  16'h0000, 16'h0000);
		send_request(siq_pkg::REQ_INSERT,  16'h0001, 16'h5555);
		send_request(siq_pkg::REQ_INSERT,  16'h7FFF, 16'h1234);
		send_request(siq_pkg::REQ_APPEND,  16'h0000, 16'hFFFF);
		send_request(siq_pkg::REQ_SEARCH,  16'h0001, 16'h0000);
		send_request(siq_pkg::REQ_SEARCH,  16'hFFFF, 16'h0000);
		send_request(siq_pkg::REQ_SEARCH,  16'h4242, 16'h0000);
		send_request(siq_pkg::REQ_PEEK,    16'h0000, 16'h0000);
		send_request(siq_pkg::REQ_DEQUEUE, 16'h0000, 16'h0000);
		send_request(RB'(siq_pkg::REQ_SEARCH + 3), 16'h5A5A, 16'hA5A5);

		// three pressure profiles, each with both key orders
		order = 1'b1;
		for (int leg = 0; leg < 3; leg++) begin
			case (leg)
				0: begin
					tx_idle_pct = 16;
					rx_idle_pct = 85;
				end
				1: begin
					tx_idle_pct = 85;
					rx_idle_pct = 16;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int half = 0; half < 2; half++) begin
				settle();
				write_order(order);
				order = !order;
				if (leg == 2 && half == 0)
					long_hold = 1'b1;
				random_burst(ITEMS_PER_LEG);
			end
		end
		settle();

		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
